// ===== hw/rtl/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared codes and command/status types of the pyramid reduce block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpr_pkg;

	localparam int NUM_CH      = 3;
	localparam int ROWCOL_BITS = 11;

	// sample source of one multiply-accumulate step
	localparam logic [1:0] SRC_CUR = 2'd0;
	localparam logic [1:0] SRC_WIN = 2'd1;
	localparam logic [1:0] SRC_HC  = 2'd2;
	localparam logic [1:0] SRC_MEM = 2'd3;

	// kernel coefficient select
	localparam logic [1:0] TAP_CENTER = 2'd0;
	localparam logic [1:0] TAP_INNER  = 2'd1;
	localparam logic [1:0] TAP_OUTER  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_WIDTH    = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_CENTER   = 3'd2;
	localparam logic [2:0] REG_INNER    = 3'd3;
	localparam logic [2:0] REG_OUTER    = 3'd4;
	localparam logic [2:0] REG_GAIN     = 3'd5;
	localparam logic [2:0] REG_DECIMATE = 3'd6;
	localparam logic [2:0] REG_CHANNELS = 3'd7;

	typedef struct packed {
		logic       valid;     // MAC step issued
		logic       first;     // clear accumulator
		logic       last;      // final tap of this sum
		logic [1:0] src;
		logic [1:0] sel;       // window slot or column buffer index
		logic [1:0] tap;
		logic [1:0] dst;       // column buffer receiving a horizontal result
		logic       vert;      // result goes to the output register
		logic       ram_we;
		logic       load_cur;
		logic       shift_win;
	} cmd_t;

	typedef struct packed {
		logic                   run_end;
		logic [ROWCOL_BITS-1:0] row;
		logic [ROWCOL_BITS-1:0] col;
	} meta_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gpr_ram.sv =====
// ----------------------------------------------------------------------------
// gpr_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_ram #(
	parameter int WIDTH = 54,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gpr_datapath.sv =====
// ----------------------------------------------------------------------------
// gpr_datapath
// Pixel window, shared 3-channel MAC, pass rounding, row store, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_datapath #(
	parameter int MAX_WIDTH   = 2048,
	parameter int SAMPLE_BITS = 18,
	parameter int COEF_BITS   = 16,
	parameter int IN_BITS     = 56,
	parameter int OUT_BITS    = 80
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [COEF_BITS-1:0]            tap_center,
	input  wire logic [COEF_BITS-1:0]            tap_inner,
	input  wire logic [COEF_BITS-1:0]            tap_outer,
	input  wire logic [1:0]                      gain_shift,
	input  wire logic [1:0]                      channel_count,
	input  wire gpr_pkg::cmd_t                   cmd,
	input  wire logic [$clog2(MAX_WIDTH)+1:0]    ram_addr,
	input  wire gpr_pkg::meta_t                  meta,
	input  wire logic [IN_BITS-1:0]              s_tdata,
	output gpr_pkg::stat_t                       stat,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [OUT_BITS-1:0]                  m_tdata,
	output logic                                 m_tlast
);

	import gpr_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int CB    = COEF_BITS;
	localparam int PW    = SB + CB + 1;
	localparam int AW    = SB + CB + 4;
	localparam int VW    = AW + 3;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int RAM_W = NUM_CH * SB;
	localparam int RAM_D = 4 * (2 ** XW);

	localparam logic signed [VW-1:0] RND  = VW'(longint'(1) << (CB - 1));
	localparam logic signed [VW-1:0] SMAX = VW'((longint'(1) << (SB - 1)) - 1);
	localparam logic signed [VW-1:0] SMIN = -SMAX - VW'(1);

	typedef logic signed [SB-1:0] smp_t;

	smp_t cur_q [NUM_CH];
	smp_t win_q [4][NUM_CH];
	smp_t hc_q  [3][NUM_CH];

	logic                 v_s1, first_s1, last_s1, mem_s1, vert_s1;
	logic [1:0]           dst_s1;
	logic [CB-1:0]        tap_s1;
	smp_t                 smp_s1 [NUM_CH];
	logic                 v_s2, first_s2, last_s2, vert_s2;
	logic [1:0]           dst_s2;
	logic signed [PW-1:0] prod_s2 [NUM_CH];
	logic signed [AW-1:0] acc_q [NUM_CH];
	logic                 fin_q, fvert_q;
	logic [1:0]           fdst_q;

	logic                 m_tvalid_q, m_tlast_q;
	logic [OUT_BITS-1:0]  m_tdata_q;

	smp_t                 smp_sel [NUM_CH];
	smp_t                 smp_mul [NUM_CH];
	smp_t                 res [NUM_CH];
	logic [CB-1:0]        tap_sel;
	logic [1:0]           gain;
	logic [1:0]           nch;
	logic [RAM_W-1:0]     ram_wdata, ram_rdata;
	logic [OUT_BITS-1:0]  out_data;

	// shift, round half up, saturate
	function automatic smp_t finish(input logic signed [AW-1:0] acc, input logic [1:0] g);
		logic signed [VW-1:0] v;
		logic signed [VW-1:0] q;
		v = VW'(acc) <<< g;
		v = v + RND;
		q = v >>> CB;
		if (q > SMAX) begin
			q = SMAX;
		end else if (q < SMIN) begin
			q = SMIN;
		end
		return SB'(q);
	endfunction

	assign gain = (gain_shift == 2'd3) ? 2'd2 : gain_shift;
	assign nch  = (channel_count == 2'd0) ? 2'd1 : channel_count;

	always_comb begin
		case (cmd.tap)
			TAP_CENTER: tap_sel = tap_center;
			TAP_INNER:  tap_sel = tap_inner;
			default:    tap_sel = tap_outer;
		endcase
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case (cmd.src)
				SRC_CUR: smp_sel[ch] = cur_q[ch];
				SRC_WIN: smp_sel[ch] = win_q[cmd.sel][ch];
				SRC_HC:  smp_sel[ch] = hc_q[cmd.sel][ch];
				default: smp_sel[ch] = '0;
			endcase
			ram_wdata[ch*SB +: SB] = hc_q[cmd.sel][ch];
			smp_mul[ch] = mem_s1 ? smp_t'(ram_rdata[ch*SB +: SB]) : smp_s1[ch];
			res[ch] = finish(acc_q[ch], gain);
		end
	end

	gpr_ram #(
		.WIDTH(RAM_W),
		.DEPTH(RAM_D)
	) u_row_store (
		.clk  (clk),
		.we   (cmd.ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// MAC pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			v_s1  <= cmd.valid;
			v_s2  <= v_s1;
			fin_q <= v_s2 & last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		mem_s1   <= cmd.src == SRC_MEM;
		vert_s1  <= cmd.vert;
		dst_s1   <= cmd.dst;
		tap_s1   <= tap_sel;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		vert_s2  <= vert_s1;
		dst_s2   <= dst_s1;
		fvert_q  <= vert_s2;
		fdst_q   <= dst_s2;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			smp_s1[ch]  <= smp_sel[ch];
			prod_s2[ch] <= smp_mul[ch] * $signed({1'b0, tap_s1});
			if (v_s2) begin
				acc_q[ch] <= first_s2 ? AW'(prod_s2[ch]) : acc_q[ch] + AW'(prod_s2[ch]);
			end
			if (cmd.load_cur) begin
				cur_q[ch] <= smp_t'(s_tdata[ch*SB +: SB]);
			end
			if (fin_q && !fvert_q) begin
				hc_q[fdst_q][ch] <= res[ch];
			end
		end
	end

	// pixel window, last four inputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					win_q[i][ch] <= '0;
				end
			end
		end else if (cmd.shift_win) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				win_q[3][ch] <= win_q[2][ch];
				win_q[2][ch] <= win_q[1][ch];
				win_q[1][ch] <= win_q[0][ch];
				win_q[0][ch] <= cur_q[ch];
			end
		end
	end

	always_comb begin
		out_data = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (2'(ch) < nch) begin
				out_data[ch*SB +: SB] = res[ch];
			end
		end
		out_data[NUM_CH*SB +: ROWCOL_BITS]               = meta.row;
		out_data[NUM_CH*SB + ROWCOL_BITS +: ROWCOL_BITS] = meta.col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_q && fvert_q) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q && fvert_q) begin
			m_tdata_q <= out_data;
			m_tlast_q <= meta.run_end;
		end
	end

	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = m_tdata_q;
	assign m_tlast       = m_tlast_q;
	assign stat.done     = fin_q;
	assign stat.out_free = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

// ===== hw/rtl/gpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpr_ctrl
// Sequencer: position tracking, border mirroring, MAC step issue, bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_ctrl #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [11:0]                  image_width,
	input  wire logic [11:0]                  image_height,
	input  wire logic                         decimate,
	input  wire logic                         restart,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	output gpr_pkg::cmd_t                     cmd,
	output logic [$clog2(MAX_WIDTH)+1:0]      ram_addr,
	output gpr_pkg::meta_t                    meta,
	input  wire gpr_pkg::stat_t               stat
);

	import gpr_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int GW = ((XW > YW) ? XW : YW) + 3;

	localparam logic signed [GW-1:0] ONE = GW'(1);
	localparam logic signed [GW-1:0] TWO = GW'(2);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_HISSUE = 3'd1;
	localparam logic [2:0] S_HWAIT  = 3'd2;
	localparam logic [2:0] S_VSEL   = 3'd3;
	localparam logic [2:0] S_VISSUE = 3'd4;
	localparam logic [2:0] S_VWAIT  = 3'd5;
	localparam logic [2:0] S_WRITE  = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	logic [2:0]           state_q;
	logic [XW-1:0]        col_q;
	logic [YW-1:0]        row_q;
	logic signed [GW-1:0] c_q, r_q, w_q, h_q;
	logic [1:0]           ncols_q, nrows_q, k_q, i_q;
	logic [2:0]           t_q;
	logic                 restart_q;

	logic signed [GW-1:0] w_cur, h_cur, c_in, r_in, x_k, y_i, dd, hp, vq, widx;
	logic [1:0]           ncols_in, nrows_in, ilast, klast;
	logic [2:0]           colok, rowok;
	logic                 pair_ok, last_pair, k_end, accept;

	function automatic logic signed [GW-1:0] clampd(input logic [11:0] v, input int hi);
		if (v < 12'd3) begin
			return GW'(3);
		end
		if (int'(v) > hi) begin
			return GW'(hi);
		end
		return GW'(v);
	endfunction

	// reflect without repeating the edge sample
	function automatic logic signed [GW-1:0] mirror(input logic signed [GW-1:0] p0,
			input logic signed [GW-1:0] n);
		logic signed [GW-1:0] p;
		p = p0;
		if (p < 0) begin
			p = -p;
		end
		if (p >= n) begin
			p = ((n - ONE) <<< 1) - p;
		end
		return p;
	endfunction

	assign w_cur = clampd(image_width, MAX_WIDTH);
	assign h_cur = clampd(image_height, MAX_HEIGHT);
	assign c_in  = ($signed(GW'(col_q)) >= w_cur) ? w_cur - ONE : $signed(GW'(col_q));
	assign r_in  = ($signed(GW'(row_q)) >= h_cur) ? h_cur - ONE : $signed(GW'(row_q));
	assign ncols_in = (c_in >= TWO) ? ((c_in == w_cur - ONE) ? 2'd3 : 2'd1) : 2'd0;
	assign nrows_in = (r_in >= TWO) ? ((r_in == h_cur - ONE) ? 2'd3 : 2'd1) : 2'd0;

	// output columns are c-2 .. c, rows r-2 .. r
	assign x_k  = c_q - TWO + $signed(GW'(k_q));
	assign y_i  = r_q - TWO + $signed(GW'(i_q));
	assign dd   = $signed(GW'(t_q)) - TWO;
	assign hp   = mirror(x_k + dd, w_q);
	assign vq   = mirror(y_i + dd, h_q);
	assign widx = c_q - ONE - hp;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			colok[j] = (2'(j) < ncols_q) && !(decimate && c_q[0] ^ 1'(j));
			rowok[j] = (2'(j) < nrows_q) && !(decimate && r_q[0] ^ 1'(j));
		end
		ilast = rowok[2] ? 2'd2 : (rowok[1] ? 2'd1 : 2'd0);
		klast = colok[2] ? 2'd2 : (colok[1] ? 2'd1 : 2'd0);
	end

	assign pair_ok   = rowok[i_q] && colok[k_q];
	assign k_end     = k_q == 2'(ncols_q - 2'd1);
	assign last_pair = k_end && (i_q == 2'(nrows_q - 2'd1));
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = state_q == S_IDLE;

	assign meta.run_end = (i_q == ilast) && (k_q == klast);
	assign meta.row     = ROWCOL_BITS'(decimate ? (y_i >>> 1) : y_i);
	assign meta.col     = ROWCOL_BITS'(decimate ? (x_k >>> 1) : x_k);

	always_comb begin
		cmd           = '0;
		ram_addr      = {r_q[1:0], x_k[XW-1:0]};
		cmd.first     = t_q == 3'd0;
		cmd.last      = t_q == 3'd4;
		cmd.dst       = k_q;
		cmd.tap       = (t_q == 3'd2) ? TAP_CENTER :
			((t_q == 3'd1 || t_q == 3'd3) ? TAP_INNER : TAP_OUTER);
		cmd.load_cur  = accept;
		cmd.shift_win = state_q == S_FINISH;
		case (state_q)
			S_HISSUE: begin
				cmd.valid = 1'b1;
				cmd.src   = (hp == c_q) ? SRC_CUR : SRC_WIN;
				cmd.sel   = widx[1:0];
			end
			S_VISSUE: begin
				cmd.valid = 1'b1;
				cmd.vert  = 1'b1;
				cmd.src   = (vq == r_q) ? SRC_HC : SRC_MEM;
				cmd.sel   = k_q;
				ram_addr  = {vq[1:0], x_k[XW-1:0]};
			end
			S_WRITE: begin
				cmd.ram_we = 1'b1;
				cmd.sel    = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			k_q       <= '0;
			i_q       <= '0;
			t_q       <= '0;
			restart_q <= 1'b0;
		end else begin
			// geometry write while the last pixel winds down: applied at finish
			restart_q <= (state_q == S_FINISH) ? 1'b0 :
				(restart_q || (restart && state_q != S_IDLE));
			case (state_q)
				S_IDLE: begin
					if (restart) begin
						col_q <= '0;
						row_q <= '0;
					end
					if (s_tvalid) begin
						k_q     <= '0;
						i_q     <= '0;
						t_q     <= '0;
						state_q <= (ncols_in != 2'd0) ? S_HISSUE : S_FINISH;
					end
				end
				S_HISSUE, S_VISSUE: begin
					if (t_q == 3'd4) begin
						t_q     <= '0;
						state_q <= (state_q == S_HISSUE) ? S_HWAIT : S_VWAIT;
					end else begin
						t_q <= t_q + 3'd1;
					end
				end
				S_HWAIT: begin
					if (stat.done) begin
						if (k_end) begin
							k_q     <= '0;
							i_q     <= '0;
							state_q <= (nrows_q == 2'd0) ? S_WRITE : S_VSEL;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_HISSUE;
						end
					end
				end
				S_VSEL, S_VWAIT: begin
					if (state_q == S_VSEL && pair_ok) begin
						if (stat.out_free) begin
							state_q <= S_VISSUE;
						end
					end else if (state_q == S_VSEL || stat.done) begin
						if (last_pair) begin
							k_q     <= '0;
							state_q <= S_WRITE;
						end else if (k_end) begin
							k_q     <= '0;
							i_q     <= i_q + 2'd1;
							state_q <= S_VSEL;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_VSEL;
						end
					end
				end
				S_WRITE: begin
					if (k_end) begin
						state_q <= S_FINISH;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_FINISH: begin
					if (restart || restart_q) begin
						col_q <= '0;
						row_q <= '0;
					end else if (c_q >= w_q - ONE) begin
						col_q <= '0;
						row_q <= (r_q >= h_q - ONE) ? '0 : YW'(r_q + ONE);
					end else begin
						col_q <= XW'(c_q + ONE);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q     <= c_in;
			r_q     <= r_in;
			w_q     <= w_cur;
			h_q     <= h_cur;
			ncols_q <= ncols_in;
			nrows_q <= nrows_in;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_pyramid_reduce.sv =====
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce
// Separable symmetric 5-tap blur with optional 2:1 decimation (pyramid REDUCE).
// ----------------------------------------------------------------------------
// Pixels enter in raster order, up to three channels each. One input pixel
// is taken at a time: for an interior pixel the block accepts it, filters
// each horizontal column, issues each emitted result, skips each decimated
// one, writes the row store and finishes, all on one shared three-channel
// multiply-accumulate unit that runs one kernel tap per cycle; a result may
// also wait for the output register to be taken. At the right edge three
// columns are filtered, and on the last row up to nine results burst out;
// tlast marks the last result a pixel causes. A pixel in the first two
// columns filters nothing; one in the first two rows filters columns but
// emits no result. A write to image_width or image_height restarts the
// frame at row 0, column 0. The user must write configuration only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_pyramid_reduce #(
	parameter int MAX_WIDTH   = 2048,
	parameter int MAX_HEIGHT  = 2048,
	parameter int SAMPLE_BITS = 18,
	parameter int COEF_BITS   = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	// configuration write port
	input  wire logic                                         cfg_we,
	input  wire logic [2:0]                                   cfg_addr,
	input  wire logic [((COEF_BITS > 12) ? COEF_BITS : 12)-1:0] cfg_data,
	// input pixels
	input  wire logic                                         s_tvalid,
	output logic                                              s_tready,
	// sample_a, sample_b, sample_c from bit 0 up, zero padded to bytes
	input  wire logic [((3*SAMPLE_BITS)+7)/8*8-1:0]           s_tdata,
	// filtered results
	output logic                                              m_tvalid,
	input  wire logic                                         m_tready,
	// result_a, result_b, result_c, out_row, out_col from bit 0 up, zero padded
	output logic [((3*SAMPLE_BITS+22)+7)/8*8-1:0]             m_tdata,
	// run_end
	output logic                                              m_tlast
);

	import gpr_pkg::*;

	localparam int IN_BITS  = ((3*SAMPLE_BITS)+7)/8*8;
	localparam int OUT_BITS = ((3*SAMPLE_BITS+22)+7)/8*8;
	localparam int XW       = $clog2(MAX_WIDTH);

	// configuration registers
	logic [11:0]          width_q, height_q;
	logic [COEF_BITS-1:0] center_q, inner_q, outer_q;
	logic [1:0]           gain_q, chan_q;
	logic                 dec_q;
	logic                 restart;

	cmd_t                 cmd;
	meta_t                meta;
	stat_t                stat;
	logic [XW+1:0]        ram_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 12'd480;
			center_q <= COEF_BITS'(24576);
			inner_q  <= COEF_BITS'(16384);
			outer_q  <= COEF_BITS'(4096);
			gain_q   <= 2'd0;
			dec_q    <= 1'b1;
			chan_q   <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WIDTH:    width_q  <= cfg_data[11:0];
				REG_HEIGHT:   height_q <= cfg_data[11:0];
				REG_CENTER:   center_q <= cfg_data[COEF_BITS-1:0];
				REG_INNER:    inner_q  <= cfg_data[COEF_BITS-1:0];
				REG_OUTER:    outer_q  <= cfg_data[COEF_BITS-1:0];
				REG_GAIN:     gain_q   <= cfg_data[1:0];
				REG_DECIMATE: dec_q    <= cfg_data[0];
				REG_CHANNELS: chan_q   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// geometry change restarts the frame
	assign restart = cfg_we && (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT);

	gpr_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (width_q),
		.image_height(height_q),
		.decimate    (dec_q),
		.restart     (restart),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.cmd         (cmd),
		.ram_addr    (ram_addr),
		.meta        (meta),
		.stat        (stat)
	);

	gpr_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.IN_BITS    (IN_BITS),
		.OUT_BITS   (OUT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.tap_center   (center_q),
		.tap_inner    (inner_q),
		.tap_outer    (outer_q),
		.gain_shift   (gain_q),
		.channel_count(chan_q),
		.cmd          (cmd),
		.ram_addr     (ram_addr),
		.meta         (meta),
		.s_tdata      (s_tdata),
		.stat         (stat),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule

`default_nettype wire

// ===== verif/gpr_checker.sv =====
// ----------------------------------------------------------------------------
// gpr_checker
// Predicts and checks the filtered pixel stream of the pyramid reduce block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module gpr_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [55:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [79:0] m_tdata,
	input  wire logic        m_tlast,
	output int               fail_count,
	output int               pending
);

	import gpr_pkg::*;

	typedef struct {
		logic [17:0] res [3];
		logic [10:0] row;
		logic [10:0] col;
		logic        last;
	} px_result_t;

	px_result_t expected_px[$];

	logic [11:0] img_w, img_h;
	logic [15:0] k_center, k_inner, k_outer;
	logic [1:0]  gain, nch_reg;
	logic        decim;

	int          win [4][3];
	int          line_buf [4][2048][3];
	int          col_pos, row_pos;

	assign pending = expected_px.size();

	function automatic int clamp_dim(logic [11:0] v);
		if (v < 3) return 3;
		if (v > 2048) return 2048;
		return int'(v);
	endfunction

	function automatic longint coef(int d);
		if (d < 0) d = -d;
		if (d == 0) return longint'(k_center);
		if (d == 1) return longint'(k_inner);
		return longint'(k_outer);
	endfunction

	function automatic int reflect(int p, int n);
		if (p < 0) p = -p;
		if (p >= n) p = 2 * (n - 1) - p;
		return p;
	endfunction

	// gain, round half up, floor shift, saturate to 18 bits
	function automatic int round_sat(longint acc);
		int     g;
		longint v, q;
		g = (gain > 2) ? 2 : int'(gain);
		v = (acc <<< g) + 64'sd32768;
		q = v >>> 16;
		if (q > 131071) q = 131071;
		if (q < -131072) q = -131072;
		return int'(q);
	endfunction

	task automatic predict_pixel(logic [55:0] data);
		int     w, h, c, r, ncols, nrows, nch, k, i, ch, d, p, s, y, x;
		int     cur [3];
		int     hcur [3][3];
		int     cols [3];
		int     rows [3];
		longint acc;
		bit     any;
		px_result_t e;
		w = clamp_dim(img_w);
		h = clamp_dim(img_h);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		nch = (nch_reg == 0) ? 1 : int'(nch_reg);
		ncols = 0;
		nrows = 0;
		any = 0;
		for (ch = 0; ch < 3; ch++) cur[ch] = int'($signed(data[18*ch +: 18]));
		if (c >= 2) begin
			cols[ncols] = c - 2; ncols++;
		end
		if (c == w - 1) begin
			cols[ncols] = w - 2; ncols++;
			cols[ncols] = w - 1; ncols++;
		end
		// horizontal pass
		for (k = 0; k < ncols; k++)
			for (ch = 0; ch < 3; ch++) begin
				acc = 0;
				for (d = -2; d <= 2; d++) begin
					p = reflect(cols[k] + d, w);
					s = (p == c) ? cur[ch] : win[(c - 1 - p) & 3][ch];
					acc += coef(d) * longint'(s);
				end
				hcur[k][ch] = round_sat(acc);
			end
		if (r >= 2) begin
			rows[nrows] = r - 2; nrows++;
		end
		if (r == h - 1) begin
			rows[nrows] = r - 1; nrows++;
			rows[nrows] = r; nrows++;
		end
		// vertical pass, raster order within the burst
		for (i = 0; i < nrows; i++)
			for (k = 0; k < ncols; k++) begin
				y = rows[i];
				x = cols[k];
				if (!(decim && ((y | x) & 1))) begin
					for (ch = 0; ch < 3; ch++) begin
						acc = 0;
						for (d = -2; d <= 2; d++) begin
							p = reflect(y + d, h);
							s = (p == r) ? hcur[k][ch] : line_buf[p & 3][x][ch];
							acc += coef(d) * longint'(s);
						end
						e.res[ch] = (ch < nch) ? 18'(round_sat(acc)) : '0;
					end
					e.row = 11'(decim ? (y >> 1) : y);
					e.col = 11'(decim ? (x >> 1) : x);
					e.last = 0;
					expected_px.insert(expected_px.size(), e);
					any = 1;
				end
			end
		if (any) expected_px[expected_px.size() - 1].last = 1;
		for (k = 0; k < ncols; k++)
			for (ch = 0; ch < 3; ch++) line_buf[r & 3][cols[k]][ch] = hcur[k][ch];
		for (i = 3; i > 0; i--) win[i] = win[i - 1];
		win[0] = cur;
		if (c >= w - 1) begin
			col_pos = 0;
			row_pos = (r >= h - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_result();
		px_result_t e;
		int         ch;
		if (expected_px.size() == 0) begin
			$error("unexpected result transaction: tdata=%h tlast=%b", m_tdata, m_tlast);
			fail_count++;
			return;
		end
		e = expected_px.pop_front();
		for (ch = 0; ch < 3; ch++)
			if (m_tdata[18*ch +: 18] !== e.res[ch]) begin
				$error("result_%s: expected %0d got %0d", (ch == 0) ? "a" : (ch == 1) ? "b" : "c",
					$signed(e.res[ch]), $signed(m_tdata[18*ch +: 18]));
				fail_count++;
			end
		if (m_tdata[64:54] !== e.row) begin
			$error("out_row: expected %0d got %0d", e.row, m_tdata[64:54]);
			fail_count++;
		end
		if (m_tdata[75:65] !== e.col) begin
			$error("out_col: expected %0d got %0d", e.col, m_tdata[75:65]);
			fail_count++;
		end
		if (m_tlast !== e.last) begin
			$error("run_end: expected %0d got %0d", e.last, m_tlast);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w = 640; img_h = 480;
			k_center = 24576; k_inner = 16384; k_outer = 4096;
			gain = 0; decim = 1; nch_reg = 3;
			col_pos = 0; row_pos = 0;
			foreach (win[i, j]) win[i][j] = 0;
			fail_count = 0;
			expected_px.delete();
		end else begin
			if (m_tvalid && m_tready) check_result();
			if (cfg_we) begin
				case (cfg_addr)
					REG_WIDTH: begin
						img_w = cfg_data[11:0]; col_pos = 0; row_pos = 0;
					end
					REG_HEIGHT: begin
						img_h = cfg_data[11:0]; col_pos = 0; row_pos = 0;
					end
					REG_CENTER:   k_center = cfg_data;
					REG_INNER:    k_inner = cfg_data;
					REG_OUTER:    k_outer = cfg_data;
					REG_GAIN:     gain = cfg_data[1:0];
					REG_DECIMATE: decim = cfg_data[0];
					REG_CHANNELS: nch_reg = cfg_data[1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) predict_pixel(s_tdata);
		end
	end

endmodule

`default_nettype wire

// ===== verif/gaussian_pyramid_reduce_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_tb
// Frame-level regression of the pyramid reduce block.
// ----------------------------------------------------------------------------
// Streams whole frames of random pixels through the block under a series of
// kernel, gain, decimation and channel settings, with random sender idles and
// receiver stalls. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module gaussian_pyramid_reduce_tb;
	import gpr_pkg::*;

	localparam int STALL_LIMIT = 20000;	// cycles with no transaction at all
	localparam int HOLD_CYCLES = 400;	// long receiver hold-off

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_addr = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;	// sample_a, sample_b, sample_c, pad
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [79:0] m_tdata;		// result_a, result_b, result_c, out_row, out_col, pad
	logic        m_tlast;

	int          fail_count, pending;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_req = 0;
	int          hold_cnt = 0;
	int          quiet_cycles = 0;
	int          pixels_sent = 0;

	gaussian_pyramid_reduce uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	gpr_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// receiver: random stalls, plus one long hold-off while hold_req is up
	always @(posedge clk) begin
		if (hold_req && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on transaction activity
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic cfg_put(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// full register set; block must be idle
	task automatic program_block(int w, int h, int cen, int inn, int outr, int g, int dec,
		int nch);
		cfg_put(REG_WIDTH, 16'(w));
		cfg_put(REG_HEIGHT, 16'(h));
		cfg_put(REG_CENTER, 16'(cen));
		cfg_put(REG_INNER, 16'(inn));
		cfg_put(REG_OUTER, 16'(outr));
		cfg_put(REG_GAIN, 16'(g));
		cfg_put(REG_DECIMATE, 16'(dec));
		cfg_put(REG_CHANNELS, 16'(nch));
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [55:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pixels_sent++;
	endtask

	// wait for all results, then let a no-result pixel finish inside the block
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	function automatic logic [17:0] rand_sample();
		case ($urandom_range(7))
			0: return 18'h1ffff;
			1: return 18'h20000;
			2: return 18'h00000;
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic [55:0] rand_pixel();
		return {2'b00, rand_sample(), rand_sample(), rand_sample()};
	endfunction

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 79; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 79; end
			default: begin send_idle_pct = 23; recv_stall_pct = 23; end
		endcase
	endtask

	task automatic send_frame(int w, int h);
		for (int i = 0; i < w * h; i++) send_pixel(rand_pixel());
		drain();
	endtask

	initial begin
		int frame_no, w, h, cen, inn, outr, tap_mode;
		frame_no = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// saturating taps, gain code three, extreme samples in a 3x3 frame
		program_block(3, 3, 65535, 65535, 65535, 3, 0, 3);
		send_pixel({2'b00, 18'h1ffff, 18'h1ffff, 18'h1ffff});
		send_pixel({2'b00, 18'h20000, 18'h20000, 18'h20000});
		send_pixel({2'b00, 18'h00000, 18'h3ffff, 18'h00001});
		send_pixel({2'b00, 18'h3ffff, 18'h00000, 18'h20000});
		send_pixel({2'b00, 18'h1ffff, 18'h20000, 18'h00000});
		send_pixel({2'b00, 18'h2aaaa, 18'h15555, 18'h3ffff});
		send_pixel({2'b00, 18'h15555, 18'h2aaaa, 18'h1ffff});
		send_pixel({2'b00, 18'h00001, 18'h1ffff, 18'h20000});
		send_pixel({2'b00, 18'h20000, 18'h00001, 18'h15555});
		drain();

		// clamped geometry: width and height under three, channel count zero
		program_block(1, 2, 24576, 16384, 4096, 0, 1, 0);
		send_frame(3, 3);

		// geometry at its top: part of a first row, which yields nothing
		program_block(4095, 4095, 0, 0, 0, 0, 1, 2);
		for (int i = 0; i < 12; i++) send_pixel(rand_pixel());
		drain();

		// back-pressure test: long hold-off while the sender keeps offering
		program_block(6, 5, 24576, 16384, 4096, 1, 0, 3);
		hold_req = 1;
		send_frame(6, 5);
		hold_req = 0;

		while (pixels_sent < 460) begin
			frame_no++;
			set_idling(frame_no);
			w = $urandom_range(3, 9);
			h = $urandom_range(3, 6);
			tap_mode = $urandom_range(3);
			cen = (tap_mode == 0) ? 65535 : (tap_mode == 1) ? 0 : $urandom_range(65535);
			inn = (tap_mode == 0) ? 65535 : (tap_mode == 1) ? 0 : $urandom_range(32768);
			outr = (tap_mode == 0) ? 65535 : (tap_mode == 1) ? 0 : $urandom_range(16384);
			program_block(w, h, cen, inn, outr, $urandom_range(3), $urandom_range(1),
				$urandom_range(3));
			send_frame(w, h);
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/gpr_pkg.sv
hw/rtl/gpr_ram.sv
hw/rtl/gpr_datapath.sv
hw/rtl/gpr_ctrl.sv
hw/rtl/gaussian_pyramid_reduce.sv
verif/gpr_checker.sv
verif/gaussian_pyramid_reduce_tb.sv
